// File: hw/rtl/limit_order_book_matcher_assert.svh
// Assertion macros used by the order book top level.
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LOBM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("order book assertion failed");

// Implication checked in the cycle after the antecedent.
`define LOBM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("order book assertion failed");

`endif

// File: hw/rtl/lobm_pkg.sv
// Shared types and constants of the limit order book matcher.
package lobm_pkg;

	localparam int NUM_LEVELS_DEF  = 64;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int SIZE_BITS_DEF   = 8;
	localparam logic [6:0] SCAN_LIMIT_RESET = 7'd100;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_CHANGE = 2'd2;
	localparam logic [1:0] OP_SWEEP  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NO_ORDER  = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic       side;
		logic [5:0] level;
		logic [3:0] position;
		logic [7:0] quantity;
		logic       increase;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  best_bid;
		logic [5:0]  best_ask;
		logic [5:0]  trade_level;
		logic        trade_side;
		logic [15:0] assigned_id;
		logic [7:0]  filled;
	} out_word_t;

endpackage

// File: hw/rtl/lobm_cnt_ram.sv
// Per-level order count memory with valid bits that reset clears.
module lobm_cnt_ram import lobm_pkg::*; #(
	parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int LW = $clog2(NUM_LEVELS),
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [LW-1:0] rd_addr,
	output logic [CW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [LW-1:0] wr_addr,
	input  logic [CW-1:0] wr_data
);

	logic [CW-1:0]         mem [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] vld_q;
	logic [CW-1:0]         rd_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// A level never written since reset reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// File: hw/rtl/limit_order_book_matcher.sv
// Top level of the limit order book matcher: sequencer, order memory, output register.
// Usage: one input word per operation (add, cancel, change size, market sweep) on
// in_valid/in_stall; exactly one result word per input on out_valid/out_stall.
// The block takes one word at a time: in_stall is high from acceptance until the
// result has been loaded into the output register.
// An add reads the level's count and writes the order; a cancel, and a change that
// removes an order, shift the orders behind the slot up in the level's queue; a
// sweep visits levels in turn (empty levels included) and shifts the level's queue
// for each order it consumes. The order memory's single read and write port and
// the count memory's registered read set the pace of each step.
// A finished result waits in the output register while out_stall is high; a new
// input word is still taken then, and its result waits in the sequencer.
// The user writes the scan limit register through cfg_wr_en/cfg_wr_data while idle;
// the block does not enforce it. Reset clears all levels (count valid bits), the best
// bid to the lowest level, the best ask to the highest, the trade level to the middle,
// and the id to 0. Order memory is undefined until written; only live slots are used.
`include "limit_order_book_matcher_assert.svh"

module limit_order_book_matcher import lobm_pkg::*; #(
	parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word,
	input  logic      cfg_wr_en,
	input  logic [6:0] cfg_wr_data
);

	localparam int LW  = $clog2(NUM_LEVELS);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int SLW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int AW  = (NUM_LEVELS * QUEUE_DEPTH > 1) ? $clog2(NUM_LEVELS * QUEUE_DEPTH) : 1;
	localparam int EW  = 16 + SIZE_BITS + 1;
	localparam int XW  = ((SIZE_BITS > 8) ? SIZE_BITS : 8) + 1;
	localparam logic [AW-1:0] QD_A = AW'(QUEUE_DEPTH);
	localparam logic [XW-1:0] SMAX = {{(XW - SIZE_BITS){1'b0}}, {SIZE_BITS{1'b1}}};
	localparam logic [LW-1:0] TOP_LV = LW'(NUM_LEVELS - 1);
	localparam logic [LW-1:0] MID_LV = LW'(NUM_LEVELS / 2);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_CRD  = 7'b0000010,
		S_CNT  = 7'b0000100,
		S_ORD  = 7'b0001000,
		S_SHF  = 7'b0010000,
		S_SHW  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t        state_q;
	logic [1:0]    op_q;
	logic          side_q;
	logic          inc_q;
	logic          rng_q;
	logic [3:0]    pos_q;
	logic [7:0]    qty_q;
	logic [LW-1:0] cur_q;
	logic [SLW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic [6:0]    j_q;
	logic          after_q;
	logic [7:0]    filled_q;
	logic [1:0]    status_q;
	logic [15:0]   id_out_q;
	logic [LW-1:0] best_bid_q;
	logic [LW-1:0] best_ask_q;
	logic [LW-1:0] last_lv_q;
	logic          last_side_q;
	logic [15:0]   next_id_q;
	logic [6:0]    scan_lim_q;
	out_word_t     out_q;
	logic          out_valid_q;
	logic          fin_go;

	logic [EW-1:0] store [NUM_LEVELS * QUEUE_DEPTH];
	logic [EW-1:0] st_rd_q;
	logic          st_we;
	logic [AW-1:0] st_waddr;
	logic [EW-1:0] st_wdata;
	logic [AW-1:0] st_raddr;
	logic [AW-1:0] base_a;

	logic [CW-1:0] cnt_rd;
	logic          cnt_we;
	logic [CW-1:0] cnt_wd;

	logic [XW-1:0] size_x;
	logic [XW-1:0] qty_x;
	logic [XW-1:0] rem_x;
	logic [XW-1:0] sum_x;
	logic [SIZE_BITS-1:0] sat_qty;
	logic [SIZE_BITS-1:0] sat_sum;
	logic [7:0]    fsum;
	logic          at_edge;
	logic          shift_more;
	logic          add_ok;

	assign base_a  = AW'(cur_q) * QD_A;
	assign st_raddr = base_a + AW'(idx_q) + ((state_q == S_SHF) ? AW'(1) : AW'(0));

	assign size_x  = XW'(st_rd_q[SIZE_BITS:1]);
	assign qty_x   = XW'(qty_q);
	assign rem_x   = XW'(qty_q - filled_q);
	assign sum_x   = size_x + qty_x;
	assign sat_qty = (qty_x > SMAX) ? SMAX[SIZE_BITS-1:0] : qty_x[SIZE_BITS-1:0];
	assign sat_sum = (sum_x > SMAX) ? SMAX[SIZE_BITS-1:0] : sum_x[SIZE_BITS-1:0];
	assign fsum    = filled_q + size_x[7:0];
	assign at_edge = side_q ? (cur_q == TOP_LV) : (cur_q == '0);
	assign shift_more = (32'(idx_q) + 32'd1) < 32'(cnt_q);
	assign add_ok  = rng_q && (32'(cnt_rd) < 32'(QUEUE_DEPTH));

	// The result leaves the sequencer only when the output register is free.
	assign fin_go  = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	lobm_cnt_ram #(
		.NUM_LEVELS (NUM_LEVELS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(cur_q),
		.rd_data(cnt_rd),
		.wr_en  (cnt_we),
		.wr_addr(cur_q),
		.wr_data(cnt_wd)
	);

	always_ff @(posedge clk) begin
		if (st_we) begin
			store[st_waddr] <= st_wdata;
		end
		st_rd_q <= store[st_raddr];
	end

	always_comb begin
		st_we    = 1'b0;
		st_waddr = base_a + AW'(idx_q);
		st_wdata = st_rd_q;
		cnt_we   = 1'b0;
		cnt_wd   = cnt_q - CW'(1);
		case (state_q)
			S_CNT: begin
				if (op_q == OP_ADD && add_ok) begin
					st_we    = 1'b1;
					st_waddr = base_a + AW'(cnt_rd);
					st_wdata = {next_id_q, sat_qty, side_q};
					cnt_we   = 1'b1;
					cnt_wd   = cnt_rd + CW'(1);
				end
			end
			S_ORD: begin
				if (op_q == OP_CHANGE) begin
					if (inc_q) begin
						st_we    = 1'b1;
						st_wdata = {st_rd_q[EW-1:SIZE_BITS+1], sat_sum, st_rd_q[0]};
					end else if (qty_x < size_x) begin
						st_we    = 1'b1;
						st_wdata = {st_rd_q[EW-1:SIZE_BITS+1],
							SIZE_BITS'(size_x - qty_x), st_rd_q[0]};
					end
				end else if (size_x > rem_x) begin
					st_we    = 1'b1;
					st_wdata = {st_rd_q[EW-1:SIZE_BITS+1],
						SIZE_BITS'(size_x - rem_x), st_rd_q[0]};
				end
			end
			S_SHW: begin
				st_we = 1'b1;
			end
			S_SHF: begin
				cnt_we = !shift_more;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			best_bid_q  <= '0;
			best_ask_q  <= TOP_LV;
			last_lv_q   <= MID_LV;
			last_side_q <= 1'b0;
			next_id_q   <= '0;
			scan_lim_q  <= SCAN_LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				scan_lim_q <= cfg_wr_data;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (in_word.opcode == OP_SWEEP && in_word.quantity == '0)
							? S_FIN : S_CRD;
					end
				end
				S_CRD: begin
					state_q <= S_CNT;
				end
				S_CNT: begin
					case (op_q)
						OP_ADD: begin
							if (add_ok) begin
								next_id_q <= next_id_q + 16'd1;
								if (!side_q && cur_q > best_bid_q) begin
									best_bid_q <= cur_q;
								end
								if (side_q && cur_q < best_ask_q) begin
									best_ask_q <= cur_q;
								end
							end
							state_q <= S_FIN;
						end
						OP_CANCEL, OP_CHANGE: begin
							if (!rng_q || 32'(pos_q) >= 32'(cnt_rd)) begin
								state_q <= S_FIN;
							end else if (op_q == OP_CANCEL) begin
								state_q <= S_SHF;
							end else begin
								state_q <= S_ORD;
							end
						end
						default: begin
							if (cnt_rd == '0 && j_q < scan_lim_q && !at_edge) begin
								state_q <= S_CRD;
							end else if (after_q) begin
								if (side_q) begin
									best_ask_q <= cur_q;
								end else begin
									best_bid_q <= cur_q;
								end
								state_q <= S_FIN;
							end else if (cnt_rd == '0) begin
								state_q <= S_FIN;
							end else begin
								last_lv_q   <= cur_q;
								last_side_q <= side_q;
								state_q     <= S_ORD;
							end
						end
					endcase
				end
				S_ORD: begin
					if (op_q == OP_CHANGE) begin
						state_q <= (!inc_q && qty_x >= size_x) ? S_SHF : S_FIN;
					end else if (size_x <= rem_x) begin
						state_q <= S_SHF;
					end else begin
						if (side_q) begin
							best_ask_q <= cur_q;
						end else begin
							best_bid_q <= cur_q;
						end
						state_q <= S_FIN;
					end
				end
				S_SHF: begin
					if (shift_more) begin
						state_q <= S_SHW;
					end else begin
						state_q <= (op_q == OP_SWEEP) ? S_CRD : S_FIN;
					end
				end
				S_SHW: begin
					state_q <= S_SHF;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operation context and per-item working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= in_word.opcode;
				side_q   <= in_word.side;
				inc_q    <= in_word.increase;
				pos_q    <= in_word.position;
				qty_q    <= in_word.quantity;
				rng_q    <= 32'(in_word.level) < 32'(NUM_LEVELS);
				idx_q    <= (in_word.opcode == OP_SWEEP) ? '0 : SLW'(in_word.position);
				cur_q    <= (in_word.opcode == OP_SWEEP)
					? (in_word.side ? best_ask_q : best_bid_q) : LW'(in_word.level);
				j_q      <= '0;
				after_q  <= 1'b0;
				filled_q <= '0;
				status_q <= ST_OK;
				id_out_q <= '0;
			end
			S_CNT: begin
				cnt_q <= cnt_rd;
				case (op_q)
					OP_ADD: begin
						if (add_ok) begin
							id_out_q <= next_id_q;
						end else begin
							status_q <= ST_FULL;
						end
					end
					OP_CANCEL, OP_CHANGE: begin
						if (!rng_q || 32'(pos_q) >= 32'(cnt_rd)) begin
							status_q <= ST_NO_ORDER;
						end
					end
					default: begin
						if (cnt_rd == '0 && j_q < scan_lim_q && !at_edge) begin
							j_q   <= j_q + 7'd1;
							cur_q <= side_q ? cur_q + LW'(1) : cur_q - LW'(1);
						end else if (cnt_rd == '0 && !after_q) begin
							status_q <= ST_EXHAUSTED;
						end
					end
				endcase
			end
			S_ORD: begin
				if (op_q == OP_SWEEP) begin
					if (size_x <= rem_x) begin
						filled_q <= fsum;
						after_q  <= (fsum == qty_q);
					end else begin
						filled_q <= qty_q;
					end
				end
			end
			S_SHF: begin
				if (!shift_more) begin
					idx_q <= '0;
					j_q   <= '0;
				end
			end
			S_SHW: begin
				idx_q <= idx_q + SLW'(1);
			end
			S_FIN: begin
				if (fin_go) begin
					out_q.status      <= status_q;
					out_q.best_bid    <= 6'(best_bid_q);
					out_q.best_ask    <= 6'(best_ask_q);
					out_q.trade_level <= 6'(last_lv_q);
					out_q.trade_side  <= last_side_q;
					out_q.assigned_id <= id_out_q;
					out_q.filled      <= filled_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	`LOBM_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_q))
	`LOBM_ASSERT_NOW(a_busy_stalls, state_q != S_IDLE, in_stall)
	`LOBM_ASSERT_NOW(a_fill_bound, state_q == S_FIN, filled_q <= qty_q)
	`LOBM_ASSERT_NEXT(a_cnt_bound, cnt_we, 32'(cnt_q) <= 32'(QUEUE_DEPTH) || op_q == OP_ADD)

endmodule

// File: test/testbench.sv
// Self-checking testbench for the limit order book matcher.
module testbench;
	import lobm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEVELS = NUM_LEVELS_DEF;
	localparam int DEPTH  = QUEUE_DEPTH_DEF;
	localparam int SMAX   = (1 << SIZE_BITS_DEF) - 1;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_word_t   in_word = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_word_t  out_word;
	logic       cfg_wr_en = 1'b0;
	logic [6:0] cfg_wr_data = '0;

	// Shadow copy of the book.
	logic [15:0] book_id [LEVELS][DEPTH];
	int          book_size [LEVELS][DEPTH];
	int          book_cnt [LEVELS];
	logic [5:0]  bid_lv, ask_lv, trade_lv;
	logic        trade_sd;
	logic [15:0] id_next;
	int          scan_lim;

	out_word_t   pending_results[$];
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          errors = 0;

	limit_order_book_matcher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always #1 clk = ~clk;

	function automatic void book_clear();
		for (int l = 0; l < LEVELS; l++) begin
			book_cnt[l] = 0;
		end
		bid_lv = '0;
		ask_lv = 6'(LEVELS - 1);
		trade_lv = 6'(LEVELS / 2);
		trade_sd = 1'b0;
		id_next = '0;
		scan_lim = int'(SCAN_LIMIT_RESET);
	endfunction

	function automatic void pop_slot(int l, int p);
		for (int k = p; k + 1 < book_cnt[l]; k++) begin
			book_id[l][k] = book_id[l][k + 1];
			book_size[l][k] = book_size[l][k + 1];
		end
		book_cnt[l]--;
	endfunction

	function automatic int skip_gap(int l, bit up);
		int j;
		j = 0;
		while (book_cnt[l] == 0 && j < scan_lim) begin
			if (up) begin
				if (l + 1 >= LEVELS) break;
				l++;
			end else begin
				if (l == 0) break;
				l--;
			end
			j++;
		end
		return l;
	endfunction

	function automatic out_word_t book_apply(in_word_t w);
		out_word_t r;
		int l, q, filled, cur, rem;
		bit up;
		r = '0;
		l = int'(w.level);
		q = int'(w.quantity);
		filled = 0;
		r.status = ST_OK;
		case (w.opcode)
			OP_ADD: begin
				if (book_cnt[l] >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					book_id[l][book_cnt[l]] = id_next;
					book_size[l][book_cnt[l]] = q > SMAX ? SMAX : q;
					book_cnt[l]++;
					r.assigned_id = id_next;
					id_next = id_next + 16'd1;
					if (!w.side && w.level > bid_lv) bid_lv = w.level;
					if (w.side && w.level < ask_lv) ask_lv = w.level;
				end
			end
			OP_CANCEL, OP_CHANGE: begin
				if (int'(w.position) >= book_cnt[l]) begin
					r.status = ST_NO_ORDER;
				end else if (w.opcode == OP_CANCEL) begin
					pop_slot(l, int'(w.position));
				end else if (w.increase) begin
					book_size[l][w.position] = book_size[l][w.position] + q > SMAX ?
						SMAX : book_size[l][w.position] + q;
				end else if (q >= book_size[l][w.position]) begin
					pop_slot(l, int'(w.position));
				end else begin
					book_size[l][w.position] -= q;
				end
			end
			default: begin
				up = w.side;
				cur = up ? int'(ask_lv) : int'(bid_lv);
				while (filled < q) begin
					rem = q - filled;
					cur = skip_gap(cur, up);
					if (book_cnt[cur] == 0) begin
						r.status = ST_EXHAUSTED;
						break;
					end
					trade_lv = 6'(cur);
					trade_sd = w.side;
					if (book_size[cur][0] <= rem) begin
						filled += book_size[cur][0];
						pop_slot(cur, 0);
						if (filled == q) begin
							cur = skip_gap(cur, up);
							if (up) ask_lv = 6'(cur);
							else bid_lv = 6'(cur);
						end
					end else begin
						book_size[cur][0] -= rem;
						filled = q;
						if (up) ask_lv = 6'(cur);
						else bid_lv = 6'(cur);
					end
				end
			end
		endcase
		r.best_bid = bid_lv;
		r.best_ask = ask_lv;
		r.trade_level = trade_lv;
		r.trade_side = trade_sd;
		r.filled = 8'(filled);
		return r;
	endfunction

	// Present one word, optionally after a random gap, and wait for acceptance.
	task automatic send_word(in_word_t w);
		@(negedge clk);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_word <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_results.insert(pending_results.size(), book_apply(w));
	endtask

	// Drop valid and wait for every result to come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_scan_limit(logic [6:0] v);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		scan_lim = int'(v);
	endtask

	function automatic in_word_t make_word(logic [1:0] op, logic sd, int lv, int pos, int qty,
			logic inc);
		in_word_t w;
		w.opcode = op;
		w.side = sd;
		w.level = 6'(lv);
		w.position = 4'(pos);
		w.quantity = 8'(qty);
		w.increase = inc;
		return w;
	endfunction

	// Mostly well-formed operations around the middle of the grid; a few raw words.
	function automatic in_word_t random_word();
		int r, lv, pos;
		logic [31:0] rnd;
		in_word_t w;
		r = $urandom_range(0, 99);
		lv = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(20, 44);
		pos = book_cnt[lv] > 0 && $urandom_range(0, 5) != 0 ?
			$urandom_range(0, book_cnt[lv] - 1) : $urandom_range(0, 15);
		rnd = $urandom;
		w = in_word_t'(rnd[$bits(in_word_t)-1:0]);
		if (r < 8) return w;
		if (r < 48) return make_word(OP_ADD, 1'($urandom_range(0, 1)), lv, pos,
			$urandom_range(0, 30) == 0 ? 0 : $urandom_range(1, 255), w.increase);
		if (r < 60) return make_word(OP_CANCEL, w.side, lv, pos, w.quantity, w.increase);
		if (r < 76) return make_word(OP_CHANGE, w.side, lv, pos,
			$urandom_range(0, 255), 1'($urandom_range(0, 1)));
		return make_word(OP_SWEEP, 1'($urandom_range(0, 1)), lv, pos,
			$urandom_range(0, 200), w.increase);
	endfunction

	always @(negedge clk) begin
		out_stall <= $urandom_range(0, 99) < stall_pct;
	end

	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with no expectation: %h", out_word);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (out_word.status !== e.status) begin
					$error("status expected %0d got %0d", e.status, out_word.status);
					errors++;
				end
				if (out_word.best_bid !== e.best_bid) begin
					$error("best_bid expected %0d got %0d", e.best_bid, out_word.best_bid);
					errors++;
				end
				if (out_word.best_ask !== e.best_ask) begin
					$error("best_ask expected %0d got %0d", e.best_ask, out_word.best_ask);
					errors++;
				end
				if (out_word.trade_level !== e.trade_level) begin
					$error("trade_level expected %0d got %0d", e.trade_level,
						out_word.trade_level);
					errors++;
				end
				if (out_word.trade_side !== e.trade_side) begin
					$error("trade_side expected %0d got %0d", e.trade_side,
						out_word.trade_side);
					errors++;
				end
				if (out_word.assigned_id !== e.assigned_id) begin
					$error("assigned_id expected %0d got %0d", e.assigned_id,
						out_word.assigned_id);
					errors++;
				end
				if (out_word.filled !== e.filled) begin
					$error("filled expected %0d got %0d", e.filled, out_word.filled);
					errors++;
				end
			end
		end
	end

	task automatic test_add_limits();
		send_word(make_word(OP_ADD, 1'b0, 0, 0, 255, 1'b0));
		send_word(make_word(OP_ADD, 1'b1, 63, 0, 1, 1'b1));
		send_word(make_word(OP_ADD, 1'b0, 40, 15, 0, 1'b0));
		send_word(make_word(OP_ADD, 1'b1, 41, 0, 10, 1'b0));
		// Fill one level completely, then one more add is refused.
		for (int i = 0; i < DEPTH + 1; i++) send_word(make_word(OP_ADD, 1'b1, 50, 0, 5, 1'b0));
	endtask

	task automatic test_cancel_change();
		send_word(make_word(OP_CANCEL, 1'b0, 50, 15, 0, 1'b0));
		send_word(make_word(OP_CANCEL, 1'b0, 7, 0, 0, 1'b0));
		send_word(make_word(OP_CHANGE, 1'b0, 50, 3, 255, 1'b1));
		send_word(make_word(OP_CHANGE, 1'b0, 50, 4, 2, 1'b0));
		send_word(make_word(OP_CHANGE, 1'b0, 50, 4, 200, 1'b0));
		send_word(make_word(OP_CHANGE, 1'b0, 9, 15, 1, 1'b1));
	endtask

	task automatic test_sweeps();
		send_word(make_word(OP_SWEEP, 1'b1, 0, 0, 0, 1'b0));
		send_word(make_word(OP_SWEEP, 1'b0, 0, 0, 1, 1'b0));
		send_word(make_word(OP_SWEEP, 1'b1, 0, 0, 7, 1'b0));
		send_word(make_word(OP_SWEEP, 1'b0, 0, 0, 255, 1'b0));
		send_word(make_word(OP_SWEEP, 1'b1, 0, 0, 255, 1'b0));
	endtask

	task automatic test_random(int n, logic [6:0] lim, int idle_pct, int st_pct);
		write_scan_limit(lim);
		send_idle_pct = idle_pct;
		stall_pct = st_pct;
		for (int i = 0; i < n; i++) send_word(random_word());
	endtask

	initial begin
		book_clear();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (5) @(posedge clk);
		test_add_limits();
		test_cancel_change();
		test_sweeps();
		test_random(460, 7'd1, 0, 0);
		test_random(460, 7'd127, 68, 0);
		test_random(460, 7'($urandom_range(2, 20)), 0, 68);
		test_random(470, SCAN_LIMIT_RESET, 21, 21);
		drain();
		if (errors == 0) begin
			$display("** limit_order_book_matcher: PASSED **");
		end else begin
			$display("** limit_order_book_matcher: FAILED **");
		end
		$finish;
	end

	initial begin
		#6ms;
		$display("** limit_order_book_matcher: FAILED **");
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_cnt_ram.sv
hw/rtl/limit_order_book_matcher.sv
test/testbench.sv
